/* rtl/core/insertion_sort_engine_macros.svh */
// Assertion macros used by the sort engine datapath.
`ifndef INSERTION_SORT_ENGINE_MACROS_SVH
`define INSERTION_SORT_ENGINE_MACROS_SVH

// Checks a same-cycle implication on clk, disabled in reset.
`define ISE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Checks a next-cycle implication on clk, disabled in reset.
`define ISE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/core/ise_pkg.sv */
`default_nettype none

package ise_pkg;

  localparam int unsigned CAPACITY_DEF   = 32;
  localparam int unsigned VALUE_BITS_DEF = 16;
  localparam int unsigned CNT_BITS       = 16;

  typedef enum logic [2:0] {
    S_LOAD,
    S_OUTER,
    S_KEY,
    S_SCAN,
    S_INSERT,
    S_OUT_LD,
    S_OUT_WAIT
  } ise_state_t;

  // controller -> datapath
  typedef struct packed {
    logic load;      // store incoming word
    logic key_rd;    // read key at outer index
    logic key_take;  // latch key, start scan
    logic scan;      // one compare/shift step
    logic insert;    // write key at front
    logic out_rd;    // read first sorted word
    logic out_load;  // fill output register
    logic out_done;  // output word taken
  } ise_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic more_outer;
    logic greater;
    logic scan_end;
    logic out_last;
  } ise_stat_t;

  function automatic logic [CNT_BITS-1:0] sat_add(input logic [CNT_BITS-1:0] c,
                                                  input logic [1:0] k);
    logic [CNT_BITS:0] s;
    s = {1'b0, c} + {{(CNT_BITS-1){1'b0}}, k};
    return s[CNT_BITS] ? {CNT_BITS{1'b1}} : s[CNT_BITS-1:0];
  endfunction

endpackage

`default_nettype wire

/* rtl/core/ise_if.sv */
`default_nettype none

interface ise_in_if import ise_pkg::*; #(
  parameter int unsigned VALUE_BITS = VALUE_BITS_DEF
) ();
  logic                  valid;
  logic                  ready;
  logic [VALUE_BITS-1:0] value;
  logic                  is_last;

  modport source (output valid, value, is_last, input ready);
  modport sink   (input valid, value, is_last, output ready);
endinterface

interface ise_out_if import ise_pkg::*; #(
  parameter int unsigned VALUE_BITS = VALUE_BITS_DEF
) ();
  logic                  valid;
  logic                  ready;
  logic [VALUE_BITS-1:0] sorted_value;
  logic                  last_out;
  logic [CNT_BITS-1:0]   compare_count;
  logic [CNT_BITS-1:0]   access_count;
  logic                  overflowed;

  modport source (output valid, sorted_value, last_out, compare_count, access_count,
                  overflowed, input ready);
  modport sink   (input valid, sorted_value, last_out, compare_count, access_count,
                  overflowed, output ready);
endinterface

`default_nettype wire

/* rtl/core/ise_ctrl.sv */
`default_nettype none

module ise_ctrl import ise_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  input  wire logic      in_last,
  output logic           in_ready,
  output logic           out_valid,
  input  wire logic      out_ready,
  input  wire ise_stat_t stat,
  output ise_cmd_t       cmd
);

  ise_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    case (state)
      S_LOAD: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          if (in_last) state_next = S_OUTER;
        end
      end
      S_OUTER: begin
        if (stat.more_outer) begin
          cmd.key_rd = 1'b1;
          state_next = S_KEY;
        end else begin
          cmd.out_rd = 1'b1;
          state_next = S_OUT_LD;
        end
      end
      S_KEY: begin
        cmd.key_take = 1'b1;
        state_next   = S_SCAN;
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (!stat.greater) begin
          state_next = S_OUTER;
        end else if (stat.scan_end) begin
          state_next = S_INSERT;
        end
      end
      S_INSERT: begin
        cmd.insert = 1'b1;
        state_next = S_OUTER;
      end
      S_OUT_LD: begin
        cmd.out_load = 1'b1;
        state_next   = S_OUT_WAIT;
      end
      S_OUT_WAIT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          cmd.out_done = 1'b1;
          state_next   = stat.out_last ? S_LOAD : S_OUT_LD;
        end
      end
      default: state_next = S_LOAD;
    endcase
  end

endmodule

`default_nettype wire

/* rtl/core/ise_datapath.sv */
`default_nettype none

`include "insertion_sort_engine_macros.svh"

module ise_datapath import ise_pkg::*; #(
  parameter int unsigned CAPACITY   = CAPACITY_DEF,
  parameter int unsigned VALUE_BITS = VALUE_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire ise_cmd_t              cmd,
  output ise_stat_t                  stat,
  input  wire logic [VALUE_BITS-1:0] value,
  output logic [VALUE_BITS-1:0]      sorted_value,
  output logic                       last_out,
  output logic [CNT_BITS-1:0]        compare_count,
  output logic [CNT_BITS-1:0]        access_count,
  output logic                       overflowed
);

  localparam int unsigned IW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  logic [VALUE_BITS-1:0] mem [CAPACITY];
  logic [VALUE_BITS-1:0] rdata;
  logic [IW-1:0]         raddr;
  logic                  wen;
  logic [IW-1:0]         waddr;
  logic [VALUE_BITS-1:0] wdata;

  logic [CW-1:0]         count;
  logic [CW-1:0]         outer;
  logic [CW-1:0]         out_idx;
  logic [IW-1:0]         scan;
  logic [VALUE_BITS-1:0] key;
  logic [CNT_BITS-1:0]   cmp_cnt;
  logic [CNT_BITS-1:0]   acc_cnt;
  logic                  dropped;
  logic                  has_room;

  assign has_room        = count < CW'(CAPACITY);
  assign stat.more_outer = outer < count;
  assign stat.greater    = $signed(rdata) > $signed(key);
  assign stat.scan_end   = scan == '0;
  assign stat.out_last   = (out_idx + 1'b1) == count;

  always_comb begin
    raddr = '0;
    wen   = 1'b0;
    waddr = '0;
    wdata = key;
    if (cmd.key_rd) raddr = outer[IW-1:0];
    if (cmd.out_rd) raddr = out_idx[IW-1:0];
    if (cmd.key_take) raddr = outer[IW-1:0] - 1'b1;
    if (cmd.scan && stat.greater) raddr = scan - 1'b1;
    if (cmd.out_done) raddr = out_idx[IW-1:0] + 1'b1;
    if (cmd.load && has_room) begin
      wen   = 1'b1;
      waddr = count[IW-1:0];
      wdata = value;
    end
    if (cmd.scan) begin
      wen   = 1'b1;
      waddr = scan + 1'b1;
      wdata = stat.greater ? rdata : key;
    end
    if (cmd.insert) begin
      wen   = 1'b1;
      waddr = '0;
      wdata = key;
    end
  end

  always_ff @(posedge clk) begin
    if (wen) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count   <= '0;
      outer   <= CW'(1);
      out_idx <= '0;
      cmp_cnt <= '0;
      acc_cnt <= '0;
      dropped <= 1'b0;
    end else begin
      if (cmd.load) begin
        if (has_room) count <= count + 1'b1;
        else dropped <= 1'b1;
      end
      if (cmd.key_take) acc_cnt <= sat_add(acc_cnt, 2'd1);
      if (cmd.scan) begin
        cmp_cnt <= sat_add(cmp_cnt, 2'd1);
        if (stat.greater) begin
          acc_cnt <= sat_add(acc_cnt, 2'd3);
        end else begin
          acc_cnt <= sat_add(acc_cnt, 2'd2);
          outer   <= outer + 1'b1;
        end
      end
      if (cmd.insert) begin
        acc_cnt <= sat_add(acc_cnt, 2'd1);
        outer   <= outer + 1'b1;
      end
      if (cmd.out_done) begin
        if (stat.out_last) begin
          count   <= '0;
          outer   <= CW'(1);
          out_idx <= '0;
          cmp_cnt <= '0;
          acc_cnt <= '0;
          dropped <= 1'b0;
        end else begin
          out_idx <= out_idx + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.key_take) begin
      key  <= rdata;
      scan <= outer[IW-1:0] - 1'b1;
    end
    if (cmd.scan && stat.greater && !stat.scan_end) scan <= scan - 1'b1;
    if (cmd.out_load) begin
      sorted_value <= rdata;
      last_out     <= stat.out_last;
    end
  end

  assign compare_count = cmp_cnt;
  assign access_count  = acc_cnt;
  assign overflowed    = dropped;

  `ISE_ASSERT_NEXT(a_step_advances, cmd.scan && !stat.greater, outer == $past(outer) + 1'b1, "outer index did not advance after placing key")
  `ISE_ASSERT_NEXT(a_scan_moves, cmd.scan && stat.greater && !stat.scan_end, scan == $past(scan) - 1'b1, "scan index did not step down after shift")
  `ISE_ASSERT_NEXT(a_run_clears, cmd.out_done && stat.out_last, count == '0 && cmp_cnt == '0 && acc_cnt == '0 && !dropped, "run state not cleared after final word")
  `ISE_ASSERT_NOW(a_out_in_range, cmd.out_load, out_idx < count, "output index beyond stored words")

endmodule

`default_nettype wire

/* rtl/core/insertion_sort_engine.sv */
// Channel   Modport  Word
// elements  sink     value, is_last
// results   source   sorted_value, last_out, compare_count, access_count, overflowed
//
// Loading: one word per cycle. Sort: each outer step passes through the outer, key
// and scan states, one scan step per comparison, plus an insert step when the key
// lands at the front, and a final outer step closes the pass.
// Output: each word is loaded into the output register, then held valid until taken.
// Reset clears the run state; the element store itself is not cleared.
// No new word is taken from the end of a run until its last result is taken.
`default_nettype none

module insertion_sort_engine import ise_pkg::*; #(
  parameter int unsigned CAPACITY   = CAPACITY_DEF,
  parameter int unsigned VALUE_BITS = VALUE_BITS_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  ise_in_if.sink    elements,
  ise_out_if.source results
);

  ise_cmd_t  cmd;
  ise_stat_t stat;

  ise_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (elements.valid),
    .in_last   (elements.is_last),
    .in_ready  (elements.ready),
    .out_valid (results.valid),
    .out_ready (results.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  ise_datapath #(
    .CAPACITY   (CAPACITY),
    .VALUE_BITS (VALUE_BITS)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .value         (elements.value),
    .sorted_value  (results.sorted_value),
    .last_out      (results.last_out),
    .compare_count (results.compare_count),
    .access_count  (results.access_count),
    .overflowed    (results.overflowed)
  );

endmodule

`default_nettype wire

/* tb/sv/ise_checker.sv */
`timescale 1ns / 1ps

module ise_checker import ise_pkg::*; #(
  parameter int unsigned CAPACITY   = CAPACITY_DEF,
  parameter int unsigned VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  ise_in_if           elements,
  ise_out_if          results,
  output int unsigned mismatches,
  output int unsigned words_waiting,
  output int unsigned runs_sorted,
  output int unsigned words_checked,
  output int unsigned runs_dropped
);

  typedef struct packed {
    logic [VALUE_BITS-1:0] value;
    logic                  last;
    logic [CNT_BITS-1:0]   compares;
    logic [CNT_BITS-1:0]   accesses;
    logic                  dropped;
  } sorted_word_t;

  logic signed [VALUE_BITS-1:0] run_values[$];
  logic                         run_overflow;
  sorted_word_t                 sorted_words[$];
  int unsigned                  error_count;
  int unsigned                  run_count;
  int unsigned                  checked_count;
  int unsigned                  overflow_runs;

  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH %s", $time, msg);
    error_count++;
  endtask

  function automatic logic [CNT_BITS-1:0] count_up(input logic [CNT_BITS-1:0] c,
                                                   input int unsigned k);
    int unsigned s;
    s = c + k;
    if (s >= (32'd1 << CNT_BITS)) return '1;
    return CNT_BITS'(s);
  endfunction

  // insertion sort of the held run, counting reads/writes/compares as the engine does
  function automatic void sort_held_run();
    logic signed [VALUE_BITS-1:0] arr[$];
    logic signed [VALUE_BITS-1:0] key;
    logic [CNT_BITS-1:0]          cmp;
    logic [CNT_BITS-1:0]          acc;
    int                           j;
    sorted_word_t                 w;
    arr = run_values;
    cmp = '0;
    acc = '0;
    for (int i = 1; i < arr.size(); i++) begin
      key = arr[i];
      acc = count_up(acc, 1);
      j = i - 1;
      while (j >= 0) begin
        cmp = count_up(cmp, 1);
        acc = count_up(acc, 1);
        if (arr[j] > key) begin
          arr[j + 1] = arr[j];
          acc = count_up(acc, 2);
          j--;
        end else begin
          break;
        end
      end
      arr[j + 1] = key;
      acc = count_up(acc, 1);
    end
    foreach (arr[k]) begin
      w.value    = arr[k];
      w.last     = (k == arr.size() - 1);
      w.compares = cmp;
      w.accesses = acc;
      w.dropped  = run_overflow;
      sorted_words.push_back(w);
    end
  endfunction

  always @(posedge clk) begin : watch
    sorted_word_t want;
    if (rst) begin
      run_values.delete();
      sorted_words.delete();
      run_overflow  = 1'b0;
      error_count   = 0;
      run_count     = 0;
      checked_count = 0;
      overflow_runs = 0;
    end else begin
      if (results.valid && results.ready) begin
        if (sorted_words.size() == 0) begin
          report_mismatch($sformatf("unexpected result word, sorted_value %0d",
                                    $signed(results.sorted_value)));
        end else begin
          want = sorted_words.pop_front();
          checked_count++;
          if (results.sorted_value !== want.value)
            report_mismatch($sformatf("sorted_value got %0d want %0d",
                                      $signed(results.sorted_value), $signed(want.value)));
          if (results.last_out !== want.last)
            report_mismatch($sformatf("last_out got %b want %b", results.last_out, want.last));
          if (results.compare_count !== want.compares)
            report_mismatch($sformatf("compare_count got %0d want %0d",
                                      results.compare_count, want.compares));
          if (results.access_count !== want.accesses)
            report_mismatch($sformatf("access_count got %0d want %0d",
                                      results.access_count, want.accesses));
          if (results.overflowed !== want.dropped)
            report_mismatch($sformatf("overflowed got %b want %b",
                                      results.overflowed, want.dropped));
          if (want.last) run_count++;
        end
      end
      if (elements.valid && elements.ready) begin
        if (run_values.size() < CAPACITY) run_values.push_back(elements.value);
        else run_overflow = 1'b1;
        if (elements.is_last) begin
          sort_held_run();
          if (run_overflow) overflow_runs++;
          run_values.delete();
          run_overflow = 1'b0;
        end
      end
    end
    mismatches    <= error_count;
    words_waiting <= sorted_words.size();
    runs_sorted   <= run_count;
    words_checked <= checked_count;
    runs_dropped  <= overflow_runs;
  end

endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
  import ise_pkg::*;

  localparam int unsigned CAPACITY     = 32;
  localparam int unsigned VALUE_BITS   = 16;
  localparam int unsigned ITEM_TARGET  = 300;
  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned DRAIN_CYCLES = 20;

  typedef enum {PACE_FLOW, PACE_COIN, PACE_SPARSE, PACE_CHOKED} sink_pace_t;
  typedef enum {VAL_WIDE, VAL_NARROW, VAL_EDGES} value_style_t;

  logic        clk;
  logic        rst;
  int unsigned mismatches;
  int unsigned words_waiting;
  int unsigned runs_sorted;
  int unsigned words_checked;
  int unsigned runs_dropped;
  int unsigned cycle_count;
  int unsigned items_sent;
  int unsigned burst_left;

  ise_in_if  #(.VALUE_BITS(VALUE_BITS)) elements_if ();
  ise_out_if #(.VALUE_BITS(VALUE_BITS)) results_if ();

  insertion_sort_engine #(.CAPACITY(CAPACITY), .VALUE_BITS(VALUE_BITS)) u_dut (
    .clk      (clk),
    .rst      (rst),
    .elements (elements_if),
    .results  (results_if)
  );

  ise_checker #(.CAPACITY(CAPACITY), .VALUE_BITS(VALUE_BITS)) u_checker (
    .clk           (clk),
    .rst           (rst),
    .elements      (elements_if),
    .results       (results_if),
    .mismatches    (mismatches),
    .words_waiting (words_waiting),
    .runs_sorted   (runs_sorted),
    .words_checked (words_checked),
    .runs_dropped  (runs_dropped)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d words still expected", cycle_count, words_waiting);
    $display("DONE: errors detected");
    $finish;
  end

  initial begin : sink_stall
    sink_pace_t  pace;
    int unsigned pace_left;
    results_if.ready = 1'b0;
    pace = PACE_FLOW;
    pace_left = 0;
    forever begin
      @(negedge clk);
      if (pace_left == 0) begin
        pace = sink_pace_t'($urandom_range(0, 3));
        pace_left = $urandom_range(16, 160);
      end
      pace_left--;
      case (pace)
        PACE_FLOW:   results_if.ready <= 1'b1;
        PACE_COIN:   results_if.ready <= ($urandom_range(0, 1) == 1);
        PACE_SPARSE: results_if.ready <= (pace_left % 4 == 0);
        default:     results_if.ready <= ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  task automatic send_word(input logic [VALUE_BITS-1:0] v, input logic last);
    elements_if.valid   <= 1'b1;
    elements_if.value   <= v;
    elements_if.is_last <= last;
    @(posedge clk);
    while (!elements_if.ready) @(posedge clk);
    @(negedge clk);
    items_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      elements_if.valid   <= 1'b0;
      elements_if.value   <= VALUE_BITS'($urandom);
      elements_if.is_last <= 1'($urandom_range(0, 1));
      repeat ($urandom_range(1, 7)) @(negedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 90) : $urandom_range(0, 12);
    end
  endtask

  task automatic send_run(input logic [VALUE_BITS-1:0] words[$]);
    foreach (words[i]) send_word(words[i], i == words.size() - 1);
  endtask

  initial begin : stimulus
    logic [VALUE_BITS-1:0] run_words[$];
    int unsigned           run_len;
    value_style_t          style;
    logic [VALUE_BITS-1:0] v;

    rst = 1'b1;
    elements_if.valid   = 1'b0;
    elements_if.value   = '0;
    elements_if.is_last = 1'b0;
    burst_left = 0;
    items_sent = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // single-word runs, extremes and both bit patterns, duplicates, sorted, reversed
    run_words = '{16'h0000};
    send_run(run_words);
    run_words = '{16'h8000};
    send_run(run_words);
    run_words = '{16'h7FFF, 16'h8000, 16'hFFFF, 16'h0000, 16'h0001, 16'h5555, 16'hAAAA};
    send_run(run_words);
    run_words = '{16'hFFFB, 16'hFFFB, 16'hFFFB, 16'h0003, 16'h0003};
    send_run(run_words);
    run_words = '{16'h0001, 16'h0002, 16'h0003, 16'h0004};
    send_run(run_words);
    run_words = '{16'h0004, 16'h0003, 16'h0002, 16'h0001, 16'h0000, 16'hFFFF};
    send_run(run_words);

    while (items_sent < ITEM_TARGET) begin
      case ($urandom_range(0, 9))
        0:       run_len = 1;
        1:       run_len = CAPACITY;
        2:       run_len = CAPACITY + $urandom_range(1, 4);
        default: run_len = $urandom_range(2, 12);
      endcase
      style = value_style_t'($urandom_range(0, 2));
      run_words.delete();
      repeat (run_len) begin
        case (style)
          VAL_WIDE:   v = VALUE_BITS'($urandom);
          VAL_NARROW: v = VALUE_BITS'($urandom_range(0, 6) - 3);
          default: begin
            case ($urandom_range(0, 4))
              0:       v = {1'b1, {(VALUE_BITS-1){1'b0}}};
              1:       v = {1'b0, {(VALUE_BITS-1){1'b1}}};
              2:       v = '1;
              3:       v = '0;
              default: v = VALUE_BITS'($urandom);
            endcase
          end
        endcase
        run_words.push_back(v);
      end
      send_run(run_words);
    end

    elements_if.valid <= 1'b0;
    while (words_waiting != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d words in %0d sorted runs, %0d of them over capacity.",
             items_sent, runs_sorted, runs_dropped);
    $display("Checked %0d result words against the predicted order and counts.", words_checked);
    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
